@@ sv/xdfr_pkg.sv @@
// Shared types, codes and helpers for the two-layer XOR packet deframer.
// No dependencies; imported by two_layer_xor_packet_deframer_unit.
package xdfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OLEN_W  = 7;
    localparam int unsigned IPOS_W  = 17;

    localparam logic [BYTE_W-1:0] OUTER_MAX_LEN = 8'd126;
    localparam logic [IPOS_W-1:0] INNER_OVERHEAD = 17'd3;

    typedef enum logic [1:0] {
        PH_LEN     = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CHECK   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RPL_NONE = 2'd0,
        RPL_ACK  = 2'd1,
        RPL_NAK  = 2'd2
    } reply_t;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_GOOD   = 2'd1,
        ST_BADSUM = 2'd2,
        ST_SHORT  = 2'd3
    } status_t;

    function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

@@ sv/two_layer_xor_packet_deframer_unit.sv @@
// Each accepted beat passes through the input register and then the result register,
// which shows its result beat until it is taken.
// Throughput: one beat per cycle while each result is taken; the input register feeds the
// deframing logic, whose state and the result register update together.
// The input side keeps taking beats while a result waits, until both stages are full.
// Reset (rst_n, asynchronous, active low) empties both stages, sets the outer
// layer to await a length byte, clears the inner layer and expects a first frame.
module two_layer_xor_packet_deframer_unit
    import xdfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              data_valid,
    output logic [BYTE_W-1:0] data_byte,
    output logic [1:0]        reply,
    output logic [1:0]        transfer_status
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              data_valid_reg, data_valid_next;
    logic [BYTE_W-1:0] data_byte_reg, data_byte_next;
    reply_t            reply_reg, reply_next;
    status_t           status_reg, status_next;

    phase_t            phase_reg, phase_next;
    logic [OLEN_W-1:0] olen_reg, olen_next;
    logic [OLEN_W-1:0] opos_reg, opos_next;
    logic [BYTE_W-1:0] osum_reg, osum_next;
    logic [IPOS_W-1:0] itotal_reg, itotal_next;
    logic [IPOS_W-1:0] ipos_c_reg, ipos_c_next;
    logic [IPOS_W-1:0] ipos_p_reg, ipos_p_next;
    logic [BYTE_W-1:0] isum_c_reg, isum_c_next;
    logic [BYTE_W-1:0] isum_p_reg, isum_p_next;
    logic [BYTE_W-1:0] size_lo_reg, size_lo_next;
    logic [BYTE_W-1:0] icheck_reg, icheck_next;
    logic              first_reg, first_next;

    logic              slot_free;
    logic              advance;
    logic [BYTE_W-1:0] b;
    logic [OLEN_W-1:0] opos_inc;
    logic [IPOS_W-1:0] ipos_inc;
    logic              ack_ok;
    logic              too_long;

    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && slot_free;
    assign in_ready  = !in_valid_reg || slot_free;

    assign b        = flip_bits(in_byte_reg);
    assign opos_inc = opos_reg + OLEN_W'(1);
    assign ipos_inc = ipos_p_reg + IPOS_W'(1);
    assign ack_ok   = (b == osum_reg);
    assign too_long = (b > OUTER_MAX_LEN);

    // outer phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                phase_next = (opos_inc >= olen_reg) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_CHECK:
            begin
                phase_next = PH_LEN;
            end
            default:
            begin
                if (too_long)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = (b[OLEN_W-1:0] == '0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        olen_next       = olen_reg;
        opos_next       = opos_reg;
        osum_next       = osum_reg;
        itotal_next     = itotal_reg;
        ipos_c_next     = ipos_c_reg;
        ipos_p_next     = ipos_p_reg;
        isum_c_next     = isum_c_reg;
        isum_p_next     = isum_p_reg;
        size_lo_next    = size_lo_reg;
        icheck_next     = icheck_reg;
        first_next      = first_reg;
        data_valid_next = 1'b0;
        data_byte_next  = '0;
        reply_next      = RPL_NONE;
        status_next     = ST_BUSY;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                osum_next = osum_reg ^ b;
                opos_next = opos_inc;
                priority if (ipos_p_reg == IPOS_W'(0))
                begin
                    size_lo_next = b;
                    isum_p_next  = isum_p_reg ^ b;
                    ipos_p_next  = ipos_inc;
                end
                else if (ipos_p_reg == IPOS_W'(1))
                begin
                    itotal_next = {1'b0, b, size_lo_reg} + INNER_OVERHEAD;
                    isum_p_next = isum_p_reg ^ b;
                    ipos_p_next = ipos_inc;
                end
                else if (ipos_p_reg >= itotal_reg)
                begin
                    ipos_p_next = ipos_p_reg;
                end
                else if (ipos_inc == itotal_reg)
                begin
                    icheck_next = b;
                    ipos_p_next = ipos_inc;
                end
                else
                begin
                    isum_p_next     = isum_p_reg ^ b;
                    ipos_p_next     = ipos_inc;
                    data_valid_next = 1'b1;
                    data_byte_next  = b;
                end
            end
            PH_CHECK:
            begin
                if (ack_ok)
                begin
                    reply_next  = RPL_ACK;
                    ipos_c_next = ipos_p_reg;
                    isum_c_next = isum_p_reg;
                    if (first_reg && (olen_reg < OLEN_W'(2)))
                    begin
                        status_next = ST_SHORT;
                        first_next  = 1'b1;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        if (ipos_p_reg >= itotal_reg)
                        begin
                            status_next = (icheck_reg == isum_p_reg) ? ST_GOOD : ST_BADSUM;
                            first_next  = 1'b1;
                        end
                    end
                    // restart the inner layer for a new transfer
                    if (status_next != ST_BUSY)
                    begin
                        itotal_next  = '0;
                        ipos_c_next  = '0;
                        ipos_p_next  = '0;
                        isum_c_next  = '0;
                        isum_p_next  = '0;
                        size_lo_next = '0;
                        icheck_next  = '0;
                    end
                end
                else
                begin
                    reply_next  = RPL_NAK;
                    ipos_p_next = ipos_c_reg;
                    isum_p_next = isum_c_reg;
                end
            end
            default:
            begin
                if (too_long)
                begin
                    reply_next  = RPL_NAK;
                    ipos_p_next = ipos_c_reg;
                    isum_p_next = isum_c_reg;
                end
                else
                begin
                    olen_next = b[OLEN_W-1:0];
                    osum_next = b;
                    opos_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEN;
            olen_reg      <= '0;
            opos_reg      <= '0;
            osum_reg      <= '0;
            itotal_reg    <= '0;
            ipos_c_reg    <= '0;
            ipos_p_reg    <= '0;
            isum_c_reg    <= '0;
            isum_p_reg    <= '0;
            size_lo_reg   <= '0;
            icheck_reg    <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                olen_reg      <= olen_next;
                opos_reg      <= opos_next;
                osum_reg      <= osum_next;
                itotal_reg    <= itotal_next;
                ipos_c_reg    <= ipos_c_next;
                ipos_p_reg    <= ipos_p_next;
                isum_c_reg    <= isum_c_next;
                isum_p_reg    <= isum_p_next;
                size_lo_reg   <= size_lo_next;
                icheck_reg    <= icheck_next;
                first_reg     <= first_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold until the next beat moves through
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            data_valid_reg <= data_valid_next;
            data_byte_reg  <= data_byte_next;
            reply_reg      <= reply_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign data_valid      = data_valid_reg;
    assign data_byte       = data_byte_reg;
    assign reply           = reply_reg;
    assign transfer_status = status_reg;

endmodule
